[rtl/division_magic_inverse_defines.svh]
// Assertion macros for the verification side of division_magic_inverse.
// Depends on nothing; included by the port checker.
`ifndef DIVISION_MAGIC_INVERSE_DEFINES_SVH
`define DIVISION_MAGIC_INVERSE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DMI_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmi assertion failed");

// Next-cycle implication, disabled while in reset.
`define DMI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmi assertion failed");

`endif

[rtl/dmi_pkg.sv]
// Shared types and constants for the division_magic_inverse block.
// No dependencies; imported by every RTL module of the block.
package dmi_pkg;

    localparam int DIVISOR_BITS = 64;
    localparam int K_BITS       = 7;
    localparam int K_LSB        = DIVISOR_BITS;
    localparam int ERR_LSB      = DIVISOR_BITS + K_BITS;
    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 72;

    // Status of an iterative unit: working, and finishing in this cycle.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Launch request for the divider.
    typedef struct packed {
        logic              start;
        logic [K_BITS-1:0] steps;
    } div_ctrl_t;

endpackage

[rtl/dmi_msb_search.sv]
// Leading-bit search: grows a run of ones one bit per cycle until it covers b - 1.
// Depends on dmi_pkg.
module dmi_msb_search #(
    parameter int WORD_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [WORD_BITS-1:0]       divisor,
    output dmi_pkg::unit_status_t      status,
    output logic [WORD_BITS-1:0]       ones,
    output logic [dmi_pkg::K_BITS-1:0] shift_count
);
    import dmi_pkg::*;

    localparam logic [K_BITS-1:0] N_MAX = K_BITS'(WORD_BITS);

    logic                 busy_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] bm1_reg;
    logic [K_BITS-1:0]    n_reg;
    logic                 stop;

    assign stop = (rem_reg >= bm1_reg) || (n_reg == N_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && stop)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= WORD_BITS'(1);
            n_reg   <= K_BITS'(1);
            bm1_reg <= divisor - WORD_BITS'(1);
        end
        else if (busy_reg && !stop)
        begin
            // append one more bit to the run of ones
            rem_reg <= {rem_reg[WORD_BITS-2:0], 1'b1};
            n_reg   <= n_reg + K_BITS'(1);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && stop;
    assign ones        = rem_reg;
    assign shift_count = n_reg;

endmodule

[rtl/dmi_divider.sv]
// Restoring divider: one quotient bit per cycle into a quotient shift register.
// Depends on dmi_pkg.
module dmi_divider #(
    parameter int WORD_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmi_pkg::div_ctrl_t    ctrl,
    input  logic [WORD_BITS-1:0]  divisor,
    input  logic [WORD_BITS-1:0]  init_rem,
    output dmi_pkg::unit_status_t status,
    output logic [WORD_BITS-1:0]  quotient
);
    import dmi_pkg::*;

    logic                 busy_reg;
    logic [K_BITS-1:0]    count_reg;
    logic [WORD_BITS:0]   rem_reg;
    logic [WORD_BITS-1:0] quo_reg;
    logic                 ge;
    logic [WORD_BITS:0]   diff;
    logic [WORD_BITS:0]   rem_next;
    logic [WORD_BITS-1:0] quo_next;
    logic                 last;

    // The remainder stays below twice the divisor, so one subtract per step suffices
    // and the restored value always fits back into WORD_BITS bits before the shift.
    assign ge       = rem_reg >= {1'b0, divisor};
    assign diff     = rem_reg - {1'b0, divisor};
    assign rem_next = {(ge ? diff[WORD_BITS-1:0] : rem_reg[WORD_BITS-1:0]), 1'b1};
    assign quo_next = {quo_reg[WORD_BITS-2:0], ge};
    assign last     = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= ctrl.steps;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                count_reg <= count_reg - K_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= {1'b0, init_rem};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && last;
    assign quotient    = quo_reg;

endmodule

[rtl/division_magic_inverse.sv]
// division_magic_inverse: for an unsigned divisor b and dividend width k, returns the
// shift n (smallest n >= 1 with 2^n >= b) and the inverse d = 1 + floor((2^(n+k)-1)/b)
// modulo 2^WORD_BITS; a zero divisor gives divide_error = 1, inverse 0, n = WORD_BITS.
// One item at a time (k saturated to WORD_BITS): the leading-bit search advances one bit
// per cycle, the restoring divider produces one quotient bit per cycle, and the finish
// state applies the final increment and transfers the result into the output register,
// holding while that register is not free; a zero divisor goes straight to the finish.
// A finished result waits in the output register while the next item is taken.
// Depends on dmi_pkg, dmi_msb_search and dmi_divider.
module division_magic_inverse #(
    parameter int WORD_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: divisor[63:0], dividend_bits[70:64], zero pad[71]
    input  logic [dmi_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: inverse[63:0], shift_count[70:64], divide_error[71]
    output logic [dmi_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import dmi_pkg::*;

    localparam logic [K_BITS-1:0] N_MAX = K_BITS'(WORD_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;
    logic [WORD_BITS-1:0]    b_reg;
    logic [K_BITS-1:0]       k_reg;
    logic [K_BITS-1:0]       n_reg;
    logic                    err_reg;

    logic                    s_accept;
    logic [WORD_BITS-1:0]    div_in;
    logic [K_BITS-1:0]       k_in;
    logic [K_BITS-1:0]       k_sat;
    logic                    b_zero;
    logic                    out_free;
    logic                    out_load;
    unit_status_t            srch_status;
    unit_status_t            div_status;
    div_ctrl_t               div_ctrl;
    logic [WORD_BITS-1:0]    srch_ones;
    logic [K_BITS-1:0]       srch_n;
    logic [WORD_BITS-1:0]    quotient;
    logic [WORD_BITS-1:0]    inverse;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign div_in   = s_tdata[WORD_BITS-1:0];
    assign k_in     = s_tdata[K_LSB +: K_BITS];
    assign k_sat    = (k_in > N_MAX) ? N_MAX : k_in;
    assign b_zero   = (div_in == '0);
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_FINISH) && out_free;
    assign inverse  = quotient + WORD_BITS'(1);

    assign div_ctrl.start = srch_status.done;
    assign div_ctrl.steps = k_reg;

    dmi_msb_search #(
        .WORD_BITS (WORD_BITS)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (s_accept && !b_zero),
        .divisor     (div_in),
        .status      (srch_status),
        .ones        (srch_ones),
        .shift_count (srch_n)
    );

    dmi_divider #(
        .WORD_BITS (WORD_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .divisor  (b_reg),
        .init_rem (srch_ones),
        .status   (div_status),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            b_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        b_reg     <= div_in;
                        k_reg     <= k_sat;
                        err_reg   <= b_zero;
                        state_reg <= b_zero ? ST_FINISH : ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (srch_status.done)
                    begin
                        n_reg     <= srch_n;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        if (err_reg)
                        begin
                            m_tdata_reg <= {1'b1, N_MAX, DIVISOR_BITS'(0)};
                        end
                        else
                        begin
                            m_tdata_reg <= {1'b0, n_reg, DIVISOR_BITS'(inverse)};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/dmi_checker.sv]
// Port-level checker for division_magic_inverse, attached by bind.
// Depends on dmi_pkg and division_magic_inverse_defines.svh.
`include "division_magic_inverse_defines.svh"

module dmi_checker #(
    parameter int WORD_BITS = 64
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [dmi_pkg::S_TDATA_BITS-1:0] s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dmi_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import dmi_pkg::*;

    // a stalled result transfer keeps its payload
    `DMI_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an error result carries a zero inverse and the full shift
    `DMI_ASSERT_IMPLIES(a_err_fields, clk, rst_n, m_tvalid && m_tdata[ERR_LSB], (m_tdata[DIVISOR_BITS-1:0] == '0) && (m_tdata[K_LSB +: K_BITS] == K_BITS'(WORD_BITS)))

    // a normal result has a shift within 1..WORD_BITS
    `DMI_ASSERT_IMPLIES(a_shift_range, clk, rst_n, m_tvalid && !m_tdata[ERR_LSB], (m_tdata[K_LSB +: K_BITS] != '0) && (m_tdata[K_LSB +: K_BITS] <= K_BITS'(WORD_BITS)))

    // every accepted item makes the block leave the ready state
    `DMI_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind division_magic_inverse dmi_checker #(.WORD_BITS(WORD_BITS)) u_dmi_checker (.*);
